[hdl/rs_erec_pkg.sv]
// Shared types, codes and GF(2^8) arithmetic for the erasure recovery core.
// No dependencies; used by rs_erasure_recovery_gf256_core and its checker.
package rs_erec_pkg;

    // Item operations
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_MARK    = 2'd1;
    localparam logic [1:0] OP_RECOVER = 2'd2;
    localparam logic [1:0] OP_ACCUM   = 2'd3;

    // Recovery status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_FEW  = 2'd1;
    localparam logic [1:0] ST_BAD_POS  = 2'd2;
    localparam logic [1:0] ST_RESERVED = 2'd3;

    // Result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_BYTE   = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_DATA_COUNT   = 2'd0;
    localparam logic [1:0] CFG_PARITY_COUNT = 2'd1;
    localparam logic [1:0] CFG_CODE_MODE    = 2'd2;

    // Field reduction polynomial
    localparam logic [8:0] GF_POLY = 9'h11D;

    // Inverse as a^254: number of multiply steps
    localparam logic [7:0] INV_STEPS = 8'd254;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_NEXT = 7'b0000100,
        S_NUM  = 7'b0001000,
        S_DEN  = 7'b0010000,
        S_INV  = 7'b0100000,
        S_COEF = 7'b1000000
    } state_t;

    // Shift-and-add GF(2^8) multiply
    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] r;
        x = {1'b0, a};
        r = 8'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                r = r ^ x[7:0];
            end
            x = {x[7:0], 1'b0};
            if (x[8])
            begin
                x = x ^ GF_POLY;
            end
        end
        return r;
    endfunction

endpackage

[hdl/rs_erasure_recovery_gf256_core.sv]
// Erasure recovery core: group bookkeeping, coefficient sequencer, byte MAC.
// Depends on rs_erec_pkg (codes, state type, GF multiply).

// One erased data block of a group is rebuilt over GF(2^8), polynomial 0x11D.
// Clear, mark and accumulate items are handled as they are accepted, so bytes
// stream at one per cycle while the core is idle and its output not stalled; a
// recovered byte is registered and appears on the output in the cycle after its
// last source byte. A start-recovery item runs a sequencer around one shared GF
// multiplier: the received map is scanned position by position, then XOR mode
// finishes. Reed-Solomon mode visits all 32 positions, skipping unselected ones;
// each selected one takes a select step, two product passes, a 254-step inverse
// by repeated multiply and a coefficient write. The input is not ready while the
// sequencer runs. No clearing pass is needed after reset.
module rs_erasure_recovery_gf256_core #(
    parameter int MAX_DATA   = 16,
    parameter int MAX_PARITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [4:0] position, [12:5] data_byte, [15:13] zero
    input  logic [1:0]  s_tuser,   // [1:0] operation
    input  logic        s_tlast,   // last_source
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [1:0] status, [9:2] recovered_byte, [15:10] zero
    output logic        m_tuser,   // result_kind
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    localparam int KCAP = (MAX_DATA < 32) ? MAX_DATA : 32;
    localparam int MCAP = (MAX_PARITY < 32) ? MAX_PARITY : 32;

    rs_erec_pkg::state_t state_reg, state_next;

    logic [4:0]  data_count_reg, parity_count_reg;
    logic        code_mode_reg;
    logic [31:0] recv_reg, recv_next;
    logic [7:0]  coef_reg [32];
    logic [7:0]  coef_next [32];
    logic [7:0]  acc_reg, acc_next;
    logic        ready_reg, ready_next;

    logic [5:0]  k_reg, k_next, total_reg, total_next;
    logic [4:0]  p_reg, p_next;
    logic [31:0] have_reg, have_next, used_reg, used_next;
    logic [5:0]  cnt_reg, cnt_next, dcnt_reg, dcnt_next;
    logic [4:0]  i_reg, i_next, j_reg, j_next;
    logic [7:0]  inv_cnt_reg, inv_cnt_next;
    logic [7:0]  num_reg, num_next, den_reg, den_next, r_reg, r_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [7:0]  out_byte_reg, out_byte_next;

    logic        in_fire;
    logic [4:0]  in_pos;
    logic [7:0]  in_byte;
    logic [4:0]  kc5;
    logic [5:0]  k_eff, m_lim, room, m_eff, total_eff;
    logic [31:0] have_eff;
    logic [7:0]  mul_a, mul_b, mul_y;
    logic [7:0]  xj;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == rs_erec_pkg::S_IDLE) && (!out_valid_reg || m_tready);
    assign in_fire   = s_tvalid && s_tready;
    assign in_pos    = s_tdata[4:0];
    assign in_byte   = s_tdata[12:5];

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {6'd0, out_byte_reg, out_status_reg};

    // Saturate group geometry from the registers
    always_comb
    begin
        kc5       = (data_count_reg == 5'd0) ? 5'd1 : data_count_reg;
        k_eff     = ({1'b0, kc5} > 6'(KCAP)) ? 6'(KCAP) : {1'b0, kc5};
        m_lim     = ({1'b0, parity_count_reg} > 6'(MCAP)) ? 6'(MCAP)
                                                          : {1'b0, parity_count_reg};
        room      = 6'd32 - k_eff;
        m_eff     = (m_lim > room) ? room : m_lim;
        total_eff = k_eff + m_eff;
        have_eff  = recv_reg & ~(32'hFFFF_FFFF << total_eff);
    end

    assign xj = 8'({3'd0, j_reg}) + 8'd1;

    // Route operands into the shared multiplier
    always_comb
    begin
        unique case (state_reg)
            rs_erec_pkg::S_NUM:
            begin
                mul_a = num_reg;
                mul_b = (8'({3'd0, p_reg}) + 8'd1) ^ xj;
            end
            rs_erec_pkg::S_DEN:
            begin
                mul_a = den_reg;
                mul_b = (8'({3'd0, i_reg}) + 8'd1) ^ xj;
            end
            rs_erec_pkg::S_INV:
            begin
                mul_a = r_reg;
                mul_b = den_reg;
            end
            rs_erec_pkg::S_COEF:
            begin
                mul_a = num_reg;
                mul_b = r_reg;
            end
            default:
            begin
                mul_a = coef_reg[in_pos];
                mul_b = in_byte;
            end
        endcase
    end

    assign mul_y = rs_erec_pkg::gmul(mul_a, mul_b);

    // Sequencer and item handling
    always_comb
    begin
        state_next      = state_reg;
        recv_next       = recv_reg;
        coef_next       = coef_reg;
        acc_next        = acc_reg;
        ready_next      = ready_reg;
        k_next          = k_reg;
        total_next      = total_reg;
        p_next          = p_reg;
        have_next       = have_reg;
        used_next       = used_reg;
        cnt_next        = cnt_reg;
        dcnt_next       = dcnt_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        inv_cnt_next    = inv_cnt_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        r_next          = r_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;

        unique case (state_reg)
            rs_erec_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (s_tuser)
                        rs_erec_pkg::OP_CLEAR:
                        begin
                            recv_next  = 32'd0;
                            acc_next   = 8'd0;
                            ready_next = 1'b0;
                            for (int e = 0; e < 32; e++)
                            begin
                                coef_next[e] = 8'd0;
                            end
                        end
                        rs_erec_pkg::OP_MARK:
                        begin
                            recv_next[in_pos] = 1'b1;
                        end
                        rs_erec_pkg::OP_RECOVER:
                        begin
                            acc_next   = 8'd0;
                            ready_next = 1'b0;
                            for (int e = 0; e < 32; e++)
                            begin
                                coef_next[e] = 8'd0;
                            end
                            k_next     = k_eff;
                            total_next = total_eff;
                            p_next     = in_pos;
                            have_next  = have_eff;
                            if (({1'b0, in_pos} >= k_eff) || have_eff[in_pos])
                            begin
                                out_valid_next  = 1'b1;
                                out_kind_next   = rs_erec_pkg::KIND_STATUS;
                                out_status_next = rs_erec_pkg::ST_BAD_POS;
                                out_byte_next   = 8'd0;
                            end
                            else
                            begin
                                used_next  = 32'd0;
                                cnt_next   = 6'd0;
                                dcnt_next  = 6'd0;
                                j_next     = 5'd0;
                                state_next = rs_erec_pkg::S_SCAN;
                            end
                        end
                        rs_erec_pkg::OP_ACCUM:
                        begin
                            if (ready_reg)
                            begin
                                if (s_tlast)
                                begin
                                    acc_next        = 8'd0;
                                    out_valid_next  = 1'b1;
                                    out_kind_next   = rs_erec_pkg::KIND_BYTE;
                                    out_status_next = rs_erec_pkg::ST_OK;
                                    out_byte_next   = acc_reg ^ mul_y;
                                end
                                else
                                begin
                                    acc_next = acc_reg ^ mul_y;
                                end
                            end
                        end
                    endcase
                end
            end

            // Pick the first K received positions; count received data blocks
            rs_erec_pkg::S_SCAN:
            begin
                if (have_reg[j_reg] && (cnt_reg < k_reg))
                begin
                    used_next[j_reg] = 1'b1;
                    cnt_next         = cnt_reg + 6'd1;
                end
                if (have_reg[j_reg] && ({1'b0, j_reg} < k_reg))
                begin
                    dcnt_next = dcnt_reg + 6'd1;
                end
                j_next = j_reg + 5'd1;
                if (j_reg == 5'd31)
                begin
                    if (!code_mode_reg)
                    begin
                        state_next      = rs_erec_pkg::S_IDLE;
                        out_valid_next  = 1'b1;
                        out_kind_next   = rs_erec_pkg::KIND_STATUS;
                        out_byte_next   = 8'd0;
                        if ((dcnt_next == k_reg - 6'd1) && (k_reg < total_reg)
                            && have_reg[k_reg[4:0]])
                        begin
                            out_status_next = rs_erec_pkg::ST_OK;
                            ready_next      = 1'b1;
                            for (int e = 0; e < 32; e++)
                            begin
                                if (have_reg[e] && (6'(e) <= k_reg))
                                begin
                                    coef_next[e] = 8'd1;
                                end
                            end
                        end
                        else
                        begin
                            out_status_next = rs_erec_pkg::ST_TOO_FEW;
                        end
                    end
                    else if (cnt_next < k_reg)
                    begin
                        state_next      = rs_erec_pkg::S_IDLE;
                        out_valid_next  = 1'b1;
                        out_kind_next   = rs_erec_pkg::KIND_STATUS;
                        out_status_next = rs_erec_pkg::ST_TOO_FEW;
                        out_byte_next   = 8'd0;
                    end
                    else
                    begin
                        i_next     = 5'd0;
                        state_next = rs_erec_pkg::S_NEXT;
                    end
                end
            end

            // Skip to the next selected position or finish
            rs_erec_pkg::S_NEXT:
            begin
                if (used_reg[i_reg])
                begin
                    num_next   = 8'd1;
                    den_next   = 8'd1;
                    j_next     = 5'd0;
                    state_next = rs_erec_pkg::S_NUM;
                end
                else if (i_reg == 5'd31)
                begin
                    state_next      = rs_erec_pkg::S_IDLE;
                    ready_next      = 1'b1;
                    out_valid_next  = 1'b1;
                    out_kind_next   = rs_erec_pkg::KIND_STATUS;
                    out_status_next = rs_erec_pkg::ST_OK;
                    out_byte_next   = 8'd0;
                end
                else
                begin
                    i_next = i_reg + 5'd1;
                end
            end

            // Lagrange numerator product over the other selected points
            rs_erec_pkg::S_NUM:
            begin
                if (used_reg[j_reg] && (j_reg != i_reg))
                begin
                    num_next = mul_y;
                end
                j_next = j_reg + 5'd1;
                if (j_reg == 5'd31)
                begin
                    state_next = rs_erec_pkg::S_DEN;
                end
            end

            // Denominator product
            rs_erec_pkg::S_DEN:
            begin
                if (used_reg[j_reg] && (j_reg != i_reg))
                begin
                    den_next = mul_y;
                end
                j_next = j_reg + 5'd1;
                if (j_reg == 5'd31)
                begin
                    r_next       = 8'd1;
                    inv_cnt_next = 8'd0;
                    state_next   = rs_erec_pkg::S_INV;
                end
            end

            // Invert the denominator by repeated multiply
            rs_erec_pkg::S_INV:
            begin
                r_next       = mul_y;
                inv_cnt_next = inv_cnt_reg + 8'd1;
                if (inv_cnt_reg == rs_erec_pkg::INV_STEPS - 8'd1)
                begin
                    state_next = rs_erec_pkg::S_COEF;
                end
            end

            // Store the coefficient and advance, or finish after the last position
            rs_erec_pkg::S_COEF:
            begin
                coef_next[i_reg] = mul_y;
                if (i_reg == 5'd31)
                begin
                    state_next      = rs_erec_pkg::S_IDLE;
                    ready_next      = 1'b1;
                    out_valid_next  = 1'b1;
                    out_kind_next   = rs_erec_pkg::KIND_STATUS;
                    out_status_next = rs_erec_pkg::ST_OK;
                    out_byte_next   = 8'd0;
                end
                else
                begin
                    i_next     = i_reg + 5'd1;
                    state_next = rs_erec_pkg::S_NEXT;
                end
            end

            default:
            begin
                state_next = rs_erec_pkg::S_IDLE;
            end
        endcase
    end

    // Control and group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= rs_erec_pkg::S_IDLE;
            data_count_reg   <= 5'd16;
            parity_count_reg <= 5'd4;
            code_mode_reg    <= 1'b1;
            recv_reg         <= 32'd0;
            acc_reg          <= 8'd0;
            ready_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int e = 0; e < 32; e++)
            begin
                coef_reg[e] <= 8'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            recv_reg      <= recv_next;
            acc_reg       <= acc_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
            coef_reg      <= coef_next;
            if (cfg_valid && cfg_ready)
            begin
                priority case (cfg_index)
                    rs_erec_pkg::CFG_DATA_COUNT:   data_count_reg   <= cfg_data;
                    rs_erec_pkg::CFG_PARITY_COUNT: parity_count_reg <= cfg_data;
                    rs_erec_pkg::CFG_CODE_MODE:    code_mode_reg    <= cfg_data[0];
                    default:                       ;
                endcase
            end
        end
    end

    // Sequencer datapath and output payload
    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        total_reg      <= total_next;
        p_reg          <= p_next;
        have_reg       <= have_next;
        used_reg       <= used_next;
        cnt_reg        <= cnt_next;
        dcnt_reg       <= dcnt_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        inv_cnt_reg    <= inv_cnt_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        r_reg          <= r_next;
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
    end

endmodule

[hdl/rs_erec_checker.sv]
// Port-level checks for rs_erasure_recovery_gf256_core, attached by bind.
// Depends on rs_erec_pkg for result kinds and status codes.
module rs_erec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Status results carry no byte
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == rs_erec_pkg::KIND_STATUS) |-> m_tdata[9:2] == 8'd0)
        else $error("status result with nonzero byte");

    // Byte results report ok
    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == rs_erec_pkg::KIND_BYTE) |-> m_tdata[1:0] == rs_erec_pkg::ST_OK)
        else $error("byte result with nonzero status");

    // Never emit the unused status code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != rs_erec_pkg::ST_RESERVED)
        else $error("reserved status code");

endmodule

bind rs_erasure_recovery_gf256_core rs_erec_checker u_rs_erec_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
